/* rtl/tlt_pkg.sv */
// ============================================================================
// tlt_pkg - ticket lock table shared definitions
// Payload types, command codes, register indexes and reset values.
// ============================================================================
`default_nettype none

package tlt_pkg;

    localparam int LOCK_COUNT_DEF = 16;

    localparam int CMD_W    = 3;
    localparam int LOCK_W   = 4;
    localparam int TICKET_W = 32;
    localparam int WAIT_W   = 16;
    localparam int CFG_IDX_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TAKE    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POLL    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TRY     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_INIT    = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_WAIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEXT_WAIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YIELD_DIST = 2'd2;

    localparam logic [WAIT_W-1:0] BASE_WAIT_RST  = 16'd512;
    localparam logic [WAIT_W-1:0] NEXT_WAIT_RST  = 16'd128;
    localparam logic [WAIT_W-1:0] YIELD_DIST_RST = 16'd20;

    localparam logic [TICKET_W-1:0] SERVING_RST = 32'd1;
    localparam logic [TICKET_W-1:0] TAIL_RST    = 32'd0;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [LOCK_W-1:0]   lock_index;
        logic [TICKET_W-1:0] ticket;
    } t_in_item;

    typedef struct packed {
        logic [TICKET_W-1:0] ticket_out;
        logic                granted;
        logic [TICKET_W-1:0] delay_cycles;
        logic                yield_hint;
        logic                lock_free;
    } t_out_item;

endpackage

`default_nettype wire

/* rtl/ticket_lock_table_top.sv */
// ============================================================================
// ticket_lock_table_top - table of ticket locks with backoff advice
// Executes one lock command per transaction and returns one result.
// ============================================================================
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------
//  in       | i_in_valid/o_in_stall | i_in_data  (tlt_pkg::t_in_item)
//  out      | o_out_valid/i_out_stall | o_out_data (tlt_pkg::t_out_item)
//  cfg      | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
//  one command per cycle while the result side is not stalled; a result passes
//  through the input register and then the output register before it is presented
//  the lock counters are read and written back in the execute cycle, so the
//  next command on the same lock sees the update; the execute path is the
//  lock read mux, the distance subtract and one 32x16 multiply
//  synchronous reset loads every lock and the configuration registers and clears the valid flags
//  a stalled result holds in the output register; input stall rises when
//  both registers hold transactions and the result side is stalled
// ============================================================================
`default_nettype none

module ticket_lock_table_top #(
    parameter int LOCK_COUNT = tlt_pkg::LOCK_COUNT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire tlt_pkg::t_in_item             i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output tlt_pkg::t_out_item                 o_out_data,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [tlt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tlt_pkg::WAIT_W-1:0]    i_cfg_data
);

    localparam int IDX_W  = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
    localparam int TW     = tlt_pkg::TICKET_W;
    localparam int PROD_W = tlt_pkg::TICKET_W + tlt_pkg::WAIT_W;

    logic [TW-1:0] r_serving [LOCK_COUNT];
    logic [TW-1:0] r_tail    [LOCK_COUNT];

    logic [tlt_pkg::WAIT_W-1:0] r_base_wait;
    logic [tlt_pkg::WAIT_W-1:0] r_next_wait;
    logic [tlt_pkg::WAIT_W-1:0] r_yield_dist;

    logic               r_in_valid;
    tlt_pkg::t_in_item  r_in_data;
    logic               r_out_valid;
    tlt_pkg::t_out_item r_out_data;

    logic               advance;
    logic               exec;
    logic               in_range;
    logic [IDX_W-1:0]   idx;
    logic [TW-1:0]      cur_s;
    logic [TW-1:0]      cur_n;
    logic [TW-1:0]      n_plus1;
    logic [TW-1:0]      distance;
    logic [PROD_W-1:0]  prod;
    logic               we_s;
    logic               we_n;
    logic [TW-1:0]      n_serving;
    logic [TW-1:0]      n_tail;
    tlt_pkg::t_out_item n_out_data;

    // handshakes
    assign advance     = !r_out_valid || !i_out_stall;
    assign exec        = r_in_valid && advance;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_data <= i_in_data;
        end
        if (exec) begin
            r_out_data <= n_out_data;
        end
    end

    // configuration registers, low 16 bits kept, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_wait  <= tlt_pkg::BASE_WAIT_RST;
            r_next_wait  <= tlt_pkg::NEXT_WAIT_RST;
            r_yield_dist <= tlt_pkg::YIELD_DIST_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tlt_pkg::REG_BASE_WAIT:  r_base_wait  <= i_cfg_data;
                tlt_pkg::REG_NEXT_WAIT:  r_next_wait  <= i_cfg_data;
                tlt_pkg::REG_YIELD_DIST: r_yield_dist <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // execute: read the addressed lock, compute result and write-back
    assign in_range = 32'(r_in_data.lock_index) < LOCK_COUNT;
    assign idx      = IDX_W'(r_in_data.lock_index);
    assign cur_s    = r_serving[idx];
    assign cur_n    = r_tail[idx];
    assign n_plus1  = cur_n + TW'(1);
    assign distance = (cur_s > r_in_data.ticket) ? (cur_s - r_in_data.ticket)
                                                 : (r_in_data.ticket - cur_s);
    assign prod     = PROD_W'(distance) * PROD_W'(r_base_wait);

    always_comb begin
        n_out_data = '0;
        we_s       = 1'b0;
        we_n       = 1'b0;
        n_serving  = cur_s;
        n_tail     = cur_n;
        if (in_range) begin
            n_out_data.lock_free = ((cur_s - cur_n) == TW'(1));
            case (r_in_data.command)
                tlt_pkg::CMD_TAKE: begin
                    we_n                  = 1'b1;
                    n_tail                = n_plus1;
                    n_out_data.ticket_out = n_plus1;
                end
                tlt_pkg::CMD_POLL: begin
                    if (cur_s == r_in_data.ticket) begin
                        n_out_data.granted = 1'b1;
                    end else begin
                        if (distance > TW'(1)) begin
                            n_out_data.delay_cycles = (|prod[PROD_W-1:TW]) ? '1
                                                                           : prod[TW-1:0];
                        end else begin
                            n_out_data.delay_cycles = TW'(r_next_wait);
                        end
                        n_out_data.yield_hint = distance > TW'(r_yield_dist);
                    end
                end
                tlt_pkg::CMD_RELEASE: begin
                    we_s      = 1'b1;
                    n_serving = cur_s + TW'(1);
                end
                tlt_pkg::CMD_TRY: begin
                    if (cur_s == n_plus1) begin
                        we_n                  = 1'b1;
                        n_tail                = cur_s;
                        n_out_data.ticket_out = cur_s;
                        n_out_data.granted    = 1'b1;
                    end
                end
                tlt_pkg::CMD_QUERY: ;
                tlt_pkg::CMD_INIT: begin
                    we_s      = 1'b1;
                    we_n      = 1'b1;
                    n_serving = tlt_pkg::SERVING_RST;
                    n_tail    = tlt_pkg::TAIL_RST;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LOCK_COUNT; k++) begin
                r_serving[k] <= tlt_pkg::SERVING_RST;
                r_tail[k]    <= tlt_pkg::TAIL_RST;
            end
        end else if (exec) begin
            if (we_s) begin
                r_serving[idx] <= n_serving;
            end
            if (we_n) begin
                r_tail[idx] <= n_tail;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/tlt_checker.sv */
// ============================================================================
// tlt_checker - port-level checks for the ticket lock table
// Watches the top-level ports and flags inconsistent results and handshakes.
// ============================================================================
`default_nettype none

module tlt_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_in_stall,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_stall,
    input wire tlt_pkg::t_out_item            o_out_data
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // input stall only when the result side is full and stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    // yield advice only comes from a poll that was not granted
    a_yield_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.yield_hint |->
            !o_out_data.granted && o_out_data.ticket_out == '0)
        else $error("yield hint on a non-poll or granted result");

    // a backoff delay never accompanies a grant or an issued ticket
    a_delay_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.delay_cycles != '0 |->
            !o_out_data.granted && o_out_data.ticket_out == '0)
        else $error("delay with grant or ticket");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind ticket_lock_table_top tlt_checker u_tlt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire

/* verif/tlt_result_checker.sv */
// ============================================================================
// tlt_result_checker - result checker for the ticket lock table
// Watches the command, result and register channels, keeps its own copy of
// the lock counters and backoff registers, predicts one result per accepted
// command and compares it field by field with what the block returns.
// ============================================================================

module tlt_result_checker #(
    parameter int LOCK_COUNT = tlt_pkg::LOCK_COUNT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_stall,
    input  wire tlt_pkg::t_in_item             i_in_data,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_stall,
    input  wire tlt_pkg::t_out_item            i_out_data,
    input  wire logic                          i_cfg_valid,
    input  wire logic                          i_cfg_ready,
    input  wire logic [tlt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tlt_pkg::WAIT_W-1:0]    i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending
);

    localparam int MAX_REPORTS = 20;

    logic [tlt_pkg::TICKET_W-1:0] serving_q [LOCK_COUNT];
    logic [tlt_pkg::TICKET_W-1:0] tail_q    [LOCK_COUNT];
    logic [tlt_pkg::WAIT_W-1:0]   base_wait_q;
    logic [tlt_pkg::WAIT_W-1:0]   next_wait_q;
    logic [tlt_pkg::WAIT_W-1:0]   yield_dist_q;

    tlt_pkg::t_out_item expected_results [$];

    // runs one lock command against the local counters and returns its result
    function automatic tlt_pkg::t_out_item exec_lock_cmd(input tlt_pkg::t_in_item req);
        tlt_pkg::t_out_item           res;
        logic [tlt_pkg::TICKET_W-1:0] srv;
        logic [tlt_pkg::TICKET_W-1:0] tail;
        logic [tlt_pkg::TICKET_W-1:0] distance;
        logic [47:0]                  product;
        res = '0;
        if (int'(req.lock_index) < LOCK_COUNT) begin
            srv  = serving_q[req.lock_index];
            tail = tail_q[req.lock_index];
            res.lock_free = ((srv - tail) == 32'd1);
            case (req.command)
                tlt_pkg::CMD_TAKE: begin
                    tail_q[req.lock_index] = tail + 32'd1;
                    res.ticket_out = tail + 32'd1;
                end
                tlt_pkg::CMD_POLL: begin
                    if (srv == req.ticket) begin
                        res.granted = 1'b1;
                    end else begin
                        distance = (srv > req.ticket) ? srv - req.ticket
                                                      : req.ticket - srv;
                        if (distance > 32'd1) begin
                            product = distance * base_wait_q;
                            res.delay_cycles = (|product[47:32]) ? '1 : product[31:0];
                        end else begin
                            res.delay_cycles = {16'd0, next_wait_q};
                        end
                        res.yield_hint = (distance > {16'd0, yield_dist_q});
                    end
                end
                tlt_pkg::CMD_RELEASE: begin
                    serving_q[req.lock_index] = srv + 32'd1;
                end
                tlt_pkg::CMD_TRY: begin
                    // only a free lock can be grabbed
                    if (srv == tail + 32'd1) begin
                        tail_q[req.lock_index] = srv;
                        res.ticket_out = srv;
                        res.granted    = 1'b1;
                    end
                end
                tlt_pkg::CMD_INIT: begin
                    serving_q[req.lock_index] = tlt_pkg::SERVING_RST;
                    tail_q[req.lock_index]    = tlt_pkg::TAIL_RST;
                end
                default: ;
            endcase
        end
        return res;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            o_fail_count++;
            if (o_fail_count <= MAX_REPORTS)
                $display("%0t: %s expected %h, got %h", $time, fname, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        tlt_pkg::t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < LOCK_COUNT; i++) begin
                serving_q[i] = tlt_pkg::SERVING_RST;
                tail_q[i]    = tlt_pkg::TAIL_RST;
            end
            base_wait_q  = tlt_pkg::BASE_WAIT_RST;
            next_wait_q  = tlt_pkg::NEXT_WAIT_RST;
            yield_dist_q = tlt_pkg::YIELD_DIST_RST;
            o_fail_count = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    tlt_pkg::REG_BASE_WAIT:  base_wait_q  = i_cfg_data;
                    tlt_pkg::REG_NEXT_WAIT:  next_wait_q  = i_cfg_data;
                    tlt_pkg::REG_YIELD_DIST: yield_dist_q = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(exec_lock_cmd(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= MAX_REPORTS)
                        $display("%0t: result with nothing expected, expected none, got %h",
                                 $time, i_out_data);
                end else begin
                    want = expected_results.pop_front();
                    check_field("ticket_out", want.ticket_out, i_out_data.ticket_out);
                    check_field("granted", 32'(want.granted), 32'(i_out_data.granted));
                    check_field("delay_cycles", want.delay_cycles,
                                i_out_data.delay_cycles);
                    check_field("yield_hint", 32'(want.yield_hint),
                                32'(i_out_data.yield_hint));
                    check_field("lock_free", 32'(want.lock_free),
                                32'(i_out_data.lock_free));
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

/* verif/testbench.sv */
// ============================================================================
// testbench - stimulus and verdict for the ticket lock table
// Drives directed lock commands, then random lock traffic over several
// backoff register settings, with random idling on both channels in all
// phases but one and a long result hold-off and a full drain in each
// phase. Checking is done by tlt_result_checker.
// ============================================================================

module testbench;

    localparam logic [tlt_pkg::CMD_W-1:0]     CMD_SPARE_6  = 3'd6;
    localparam logic [tlt_pkg::CMD_W-1:0]     CMD_SPARE_7  = 3'd7;
    localparam logic [tlt_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    localparam int WAIT_BITS   = tlt_pkg::WAIT_W;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 60;
    localparam int PHASE_ITEMS = 250;
    localparam int NUM_PHASES  = 6;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          in_valid;
    logic                          in_stall;
    tlt_pkg::t_in_item             in_data;
    logic                          out_valid;
    logic                          out_stall;
    tlt_pkg::t_out_item            out_data;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [tlt_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tlt_pkg::WAIT_W-1:0]    cfg_data;

    int fail_count;
    int pending;
    int quiet_cycles;
    bit idle_en;
    bit hold_req;

    ticket_lock_table_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    tlt_result_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 5) < 3)
            return 0;
        return $urandom_range(1, 3);
    endfunction

    // result side back-pressure
    initial begin : receiver
        int run;
        run = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (run > 0) begin
                run--;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                out_stall = 1'b1;
                run       = HOLD_CYCLES;
            end else if (!idle_en) begin
                out_stall = 1'b0;
            end else if ($urandom_range(0, 2) == 0) begin
                out_stall = 1'b1;
                run       = pick_gap();
            end else begin
                out_stall = 1'b0;
                run       = $urandom_range(0, 8);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_cmd(input logic [tlt_pkg::CMD_W-1:0] cmd,
                            input logic [tlt_pkg::LOCK_W-1:0] lk,
                            input logic [tlt_pkg::TICKET_W-1:0] tkt);
        int gap;
        in_data.command    = cmd;
        in_data.lock_index = lk;
        in_data.ticket     = tkt;
        in_valid           = 1'b1;
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
        if (idle_en) begin
            gap = pick_gap();
            if (gap > 0) begin
                in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [tlt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tlt_pkg::WAIT_W-1:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // lock traffic focused on a few locks so queues build up and drain
    task automatic run_traffic(input int count);
        int                           sel;
        int                           lk_sel;
        logic [tlt_pkg::LOCK_W-1:0]   lk;
        logic [tlt_pkg::TICKET_W-1:0] tkt;
        logic [tlt_pkg::CMD_W-1:0]    cmd;
        for (int k = 0; k < count; k++) begin
            if (k == count / 3)
                hold_req = 1'b1;
            if (k == (2 * count) / 3)
                drain();
            lk_sel = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                 : $urandom_range(0, 3);
            lk  = lk_sel[tlt_pkg::LOCK_W-1:0];
            sel = $urandom_range(0, 15);
            if (sel < 2)
                tkt = $urandom;
            else if (sel == 2)
                tkt = 32'hFFFF_FFFF - $urandom_range(0, 3);
            else
                tkt = $urandom_range(0, 48);
            sel = $urandom_range(0, 99);
            if (sel < 20)      cmd = tlt_pkg::CMD_TAKE;
            else if (sel < 52) cmd = tlt_pkg::CMD_POLL;
            else if (sel < 70) cmd = tlt_pkg::CMD_RELEASE;
            else if (sel < 82) cmd = tlt_pkg::CMD_TRY;
            else if (sel < 88) cmd = tlt_pkg::CMD_QUERY;
            else if (sel < 92) cmd = tlt_pkg::CMD_INIT;
            else if (sel < 96) cmd = CMD_SPARE_6;
            else               cmd = CMD_SPARE_7;
            send_cmd(cmd, lk, tkt);
        end
    endtask

    logic [tlt_pkg::WAIT_W-1:0] base_set  [NUM_PHASES] =
        '{16'd0, 16'hFFFF, 16'd1, 16'd0, 16'hFFFF, 16'd300};
    logic [tlt_pkg::WAIT_W-1:0] next_set  [NUM_PHASES] =
        '{16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd0, 16'd7};
    logic [tlt_pkg::WAIT_W-1:0] yield_set [NUM_PHASES] =
        '{16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd0, 16'd5};

    initial begin
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        idle_en   = 1'b1;
        hold_req  = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part on reset register values
        send_cmd(tlt_pkg::CMD_TAKE,    4'd0,  32'd0);
        send_cmd(tlt_pkg::CMD_POLL,    4'd0,  32'd1);
        send_cmd(tlt_pkg::CMD_POLL,    4'd0,  32'd2);
        send_cmd(tlt_pkg::CMD_POLL,    4'd0,  32'd0);
        send_cmd(tlt_pkg::CMD_POLL,    4'd0,  32'd21);
        send_cmd(tlt_pkg::CMD_POLL,    4'd0,  32'd22);
        send_cmd(tlt_pkg::CMD_POLL,    4'd0,  32'hFFFF_FFFF);
        send_cmd(tlt_pkg::CMD_POLL,    4'd0,  32'h0080_0001);
        send_cmd(tlt_pkg::CMD_POLL,    4'd0,  32'h007F_FFFF);
        send_cmd(tlt_pkg::CMD_QUERY,   4'd0,  32'hFFFF_FFFF);
        send_cmd(tlt_pkg::CMD_TRY,     4'd0,  32'd0);
        send_cmd(tlt_pkg::CMD_RELEASE, 4'd0,  32'd0);
        send_cmd(tlt_pkg::CMD_QUERY,   4'd0,  32'd0);
        send_cmd(tlt_pkg::CMD_TRY,     4'd0,  32'd0);
        send_cmd(tlt_pkg::CMD_TRY,     4'd15, 32'd0);
        send_cmd(tlt_pkg::CMD_TAKE,    4'd15, 32'd0);
        send_cmd(tlt_pkg::CMD_INIT,    4'd15, 32'd0);
        send_cmd(tlt_pkg::CMD_QUERY,   4'd15, 32'd0);
        send_cmd(tlt_pkg::CMD_RELEASE, 4'd3,  32'd0);
        send_cmd(tlt_pkg::CMD_POLL,    4'd3,  32'd0);
        send_cmd(CMD_SPARE_6,          4'd3,  32'd5);
        send_cmd(CMD_SPARE_7,          4'd0,  32'd0);
        send_cmd(tlt_pkg::CMD_POLL,    4'd15, 32'h8000_0000);
        send_cmd(tlt_pkg::CMD_INIT,    4'd0,  32'd0);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            write_reg(tlt_pkg::REG_BASE_WAIT,
                      (ph == 3) ? WAIT_BITS'($urandom) : base_set[ph]);
            write_reg(tlt_pkg::REG_NEXT_WAIT,
                      (ph == 3) ? WAIT_BITS'($urandom) : next_set[ph]);
            write_reg(tlt_pkg::REG_YIELD_DIST,
                      (ph == 3) ? WAIT_BITS'($urandom_range(0, 40)) : yield_set[ph]);
            if (ph == 2)
                write_reg(REG_UNMAPPED, WAIT_BITS'($urandom));
            idle_en = (ph != 1);
            run_traffic(PHASE_ITEMS);
        end

        drain();
        repeat (4) @(negedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
